### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TICKS_PER_BIT = 3;
    localparam int BYTE_TICKS    = TICKS_PER_BIT * BITS_PER_BYTE + TICKS_PER_BIT;
    localparam int STEP_W        = $clog2(BYTE_TICKS);

    // Raw op codes on the input port
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_RSTART = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    typedef enum logic [2:0] {
        CMD_IDLE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_RSTART = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_WRITE  = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    // One classified tick travelling from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_data;
        logic       master_ack;
        logic       sda_in;
    } tick_item_t;

    // Index of the final tick of a command sequence
    function automatic logic [STEP_W-1:0] seq_last(input cmd_t cmd);
        logic [STEP_W-1:0] last;
        unique case (cmd)
            CMD_START, CMD_STOP: last = STEP_W'(2);
            CMD_RSTART:          last = STEP_W'(3);
            default:             last = STEP_W'(BYTE_TICKS - 1);
        endcase
        return last;
    endfunction

endpackage

`default_nettype wire

### rtl/i2cm_front.sv
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] op,
    input  wire logic [7:0] tx_data,
    input  wire logic       master_ack,
    input  wire logic       sda_in,
    output tick_item_t      item,
    output logic            push_valid,
    input  wire logic       push_ready
);

    logic       valid_reg;
    tick_item_t item_reg;
    cmd_t       cmd_dec;

    // Undefined codes fall through to a plain tick
    always_comb
    begin
        unique case (op)
            OP_START:  cmd_dec = CMD_START;
            OP_RSTART: cmd_dec = CMD_RSTART;
            OP_STOP:   cmd_dec = CMD_STOP;
            OP_WRITE:  cmd_dec = CMD_WRITE;
            OP_READ:   cmd_dec = CMD_READ;
            default:   cmd_dec = CMD_IDLE;
        endcase
    end

    assign in_ready = !valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd        <= cmd_dec;
            item_reg.tx_data    <= tx_data;
            item_reg.master_ack <= master_ack;
            item_reg.sda_in     <= sda_in;
        end
    end

    assign item       = item_reg;
    assign push_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/i2cm_queue.sv
`default_nettype none

module i2cm_queue
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire tick_item_t wr_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output tick_item_t      rd_item
);

    localparam int DEPTH = 2;

    tick_item_t       mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = (count_reg != 2'd0) && pop_ready;
    assign pop_valid  = (count_reg != 2'd0);
    assign rd_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

### rtl/i2cm_back.sv
`default_nettype none

module i2cm_back
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    output logic            pop_ready,
    input  wire tick_item_t item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_low,
    output logic            sda_low,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      rx_data,
    output logic            slave_acked
);

    localparam logic [STEP_W-1:0] DATA_TICKS = STEP_W'(TICKS_PER_BIT * BITS_PER_BYTE);

    cmd_t              cmd_reg, cmd_next, cur_cmd;
    logic [STEP_W-1:0] step_reg, step_next, s;
    logic [1:0]        phase_reg, phase_next, r;
    logic [7:0]        shift_reg, shift_next;
    logic              ack_choice_reg, ack_choice_next;
    logic              slave_ack_reg, slave_ack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [7:0]        rx_reg, rx_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              valid_reg;
    logic              load;
    logic              is_read;
    logic              pop;

    // State only moves when the output slot can take the new result
    assign pop_ready = !valid_reg || out_ready;
    assign pop       = q_valid && pop_ready;

    always_comb
    begin
        load            = (cmd_reg == CMD_IDLE) && (item.cmd != CMD_IDLE);
        cur_cmd         = load ? item.cmd : cmd_reg;
        s               = load ? '0 : step_reg;
        r               = load ? 2'd0 : phase_reg;
        is_read         = (cur_cmd == CMD_READ);
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        if (load && item.cmd == CMD_WRITE)
        begin
            shift_next = item.tx_data;
        end
        if (load && item.cmd == CMD_READ)
        begin
            shift_next      = 8'h00;
            ack_choice_next = item.master_ack;
        end

        cmd_next       = cur_cmd;
        step_next      = step_reg;
        phase_next     = phase_reg;
        slave_ack_next = slave_ack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rx_next        = rx_reg;
        busy_next      = 1'b0;
        done_next      = 1'b0;

        if (cur_cmd != CMD_IDLE)
        begin
            busy_next = 1'b1;
            unique case (cur_cmd)
                CMD_START:
                begin
                    if (s == STEP_W'(0))
                    begin
                        sda_next = 1'b0;
                        scl_next = 1'b0;
                    end
                    else if (s == STEP_W'(1))
                    begin
                        sda_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b1;
                    end
                end
                CMD_RSTART:
                begin
                    if (s == STEP_W'(0))
                    begin
                        sda_next = 1'b0;
                    end
                    else if (s == STEP_W'(1))
                    begin
                        scl_next = 1'b0;
                    end
                    else if (s == STEP_W'(2))
                    begin
                        sda_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (s == STEP_W'(0))
                    begin
                        sda_next = 1'b1;
                    end
                    else if (s == STEP_W'(1))
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_next = 1'b0;
                    end
                end
                default:
                begin
                    // Byte transfer: three ticks a bit, then the acknowledge bit
                    if (s < DATA_TICKS)
                    begin
                        if (r == 2'd0)
                        begin
                            sda_next = is_read ? 1'b0 : ~shift_next[7];
                        end
                        else if (r == 2'd1)
                        begin
                            scl_next = 1'b0;
                        end
                        else
                        begin
                            shift_next = {shift_next[6:0], is_read & item.sda_in};
                            scl_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (r == 2'd0)
                        begin
                            sda_next = is_read ? ack_choice_next : 1'b0;
                        end
                        else if (r == 2'd1)
                        begin
                            scl_next = 1'b0;
                        end
                        else
                        begin
                            if (is_read)
                            begin
                                rx_next = shift_next;
                            end
                            else
                            begin
                                slave_ack_next = ~item.sda_in;
                            end
                            scl_next = 1'b1;
                        end
                    end
                end
            endcase

            if (s == seq_last(cur_cmd))
            begin
                done_next  = 1'b1;
                cmd_next   = CMD_IDLE;
                step_next  = '0;
                phase_next = 2'd0;
            end
            else
            begin
                step_next  = s + STEP_W'(1);
                phase_next = (r == 2'd2) ? 2'd0 : r + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_IDLE;
            step_reg       <= '0;
            phase_reg      <= 2'd0;
            shift_reg      <= 8'h00;
            ack_choice_reg <= 1'b0;
            slave_ack_reg  <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
            rx_reg         <= 8'h00;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cmd_reg        <= cmd_next;
                step_reg       <= step_next;
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                ack_choice_reg <= ack_choice_next;
                slave_ack_reg  <= slave_ack_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                rx_reg         <= rx_next;
                busy_reg       <= busy_next;
                done_reg       <= done_next;
            end
            if (pop_ready)
            begin
                valid_reg <= q_valid;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign scl_low     = scl_reg;
    assign sda_low     = sda_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign rx_data     = rx_reg;
    assign slave_acked = slave_ack_reg;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> busy_reg)
        else $error("done without busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (cmd_reg == CMD_IDLE && step_reg == '0))
        else $error("sequence finished but command still held");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg < STEP_W'(BYTE_TICKS)) && (phase_reg != 2'd3))
        else $error("step or phase out of range");
    a_busy_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cmd_reg != CMD_IDLE) |-> (busy_reg && !done_reg))
        else $error("running command reported as idle or done");
`endif

endmodule

`default_nettype wire

### rtl/i2c_master_bit_sequencer_unit.sv
// A tick item passes the front register, the queue and the sequencer output register.
// Throughput: one tick item per cycle when not stalled; the sequencer advances one
// bus phase per item. A full output register stalls the sequencer; the 2-entry queue
// absorbs front traffic.
// Reset (rst_n low, asynchronous): idle, SCL and SDA released, rx_data and slave_acked 0.
`default_nettype none

module i2c_master_bit_sequencer_unit
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] op,
    input  wire logic [7:0] tx_data,
    input  wire logic       master_ack,
    input  wire logic       sda_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_low,
    output logic            sda_low,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      rx_data,
    output logic            slave_acked
);

    tick_item_t front_item;
    tick_item_t queue_item;
    logic       front_push_valid;
    logic       q_push_ready;
    logic       queue_pop_valid;
    logic       back_pop_ready;

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .tx_data    (tx_data),
        .master_ack (master_ack),
        .sda_in     (sda_in),
        .item       (front_item),
        .push_valid (front_push_valid),
        .push_ready (q_push_ready)
    );

    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_push_valid),
        .push_ready (q_push_ready),
        .wr_item    (front_item),
        .pop_valid  (queue_pop_valid),
        .pop_ready  (back_pop_ready),
        .rd_item    (queue_item)
    );

    i2cm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (queue_pop_valid),
        .pop_ready   (back_pop_ready),
        .item        (queue_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_low     (scl_low),
        .sda_low     (sda_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_data     (rx_data),
        .slave_acked (slave_acked)
    );

endmodule

`default_nettype wire

### test/i2c_bus_checker.sv
`timescale 1ns / 1ps

module i2c_bus_checker
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  tx_data,
    input  logic        master_ack,
    input  logic        sda_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        scl_low,
    input  logic        sda_low,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [7:0]  rx_data,
    input  logic        slave_acked,
    output int unsigned pending,
    output int unsigned fail_count
);

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       acked;
    } bus_view_t;

    // Sequencer image
    cmd_t       active_cmd;
    logic [4:0] phase;
    logic [7:0] shifter;
    logic       ack_sel;
    logic       slave_ack_q;
    logic       scl_q;
    logic       sda_q;
    logic [7:0] rx_q;

    bus_view_t  predicted_views[$];
    bus_view_t  want;
    bus_view_t  got;

    function automatic logic [4:0] final_phase(input cmd_t c);
        case (c)
            CMD_START, CMD_STOP: return 5'd2;
            CMD_RSTART:          return 5'd3;
            default:             return 5'(BYTE_TICKS - 1);
        endcase
    endfunction

    task automatic byte_phase(input bit reading, input logic sda_bit);
        logic [1:0] slot;
        slot = 2'(phase % 5'd3);
        if (phase < 5'(3 * BITS_PER_BYTE))
        begin
            case (slot)
                2'd0: sda_q = reading ? 1'b0 : ~shifter[7];
                2'd1: scl_q = 1'b0;
                default:
                begin
                    // sample on the tick that pulls SCL low again
                    shifter = {shifter[6:0], reading ? sda_bit : 1'b0};
                    scl_q = 1'b1;
                end
            endcase
        end
        else
        begin
            case (slot)
                2'd0: sda_q = reading ? ack_sel : 1'b0;
                2'd1: scl_q = 1'b0;
                default:
                begin
                    if (reading)
                        rx_q = shifter;
                    else
                        slave_ack_q = ~sda_bit;
                    scl_q = 1'b1;
                end
            endcase
        end
    endtask

    task automatic advance_tick(input logic [2:0] code, input logic [7:0] tx,
                                input logic mack, input logic sda_bit,
                                output bus_view_t view);
        logic busy;
        logic done;
        busy = 1'b0;
        done = 1'b0;
        // commands count only while idle; spare codes act as plain ticks
        if (active_cmd == CMD_IDLE && code >= OP_START && code <= OP_READ)
        begin
            active_cmd = cmd_t'(code);
            phase = '0;
            if (code == OP_WRITE)
                shifter = tx;
            if (code == OP_READ)
            begin
                shifter = '0;
                ack_sel = mack;
            end
        end
        if (active_cmd != CMD_IDLE)
        begin
            busy = 1'b1;
            case (active_cmd)
                CMD_START:
                begin
                    if (phase == 5'd0)
                    begin
                        sda_q = 1'b0;
                        scl_q = 1'b0;
                    end
                    else if (phase == 5'd1)
                        sda_q = 1'b1;
                    else
                        scl_q = 1'b1;
                end
                CMD_RSTART:
                begin
                    if (phase == 5'd0)
                        sda_q = 1'b0;
                    else if (phase == 5'd1)
                        scl_q = 1'b0;
                    else if (phase == 5'd2)
                        sda_q = 1'b1;
                    else
                        scl_q = 1'b1;
                end
                CMD_STOP:
                begin
                    if (phase == 5'd0)
                        sda_q = 1'b1;
                    else if (phase == 5'd1)
                        scl_q = 1'b0;
                    else
                        sda_q = 1'b0;
                end
                CMD_WRITE: byte_phase(1'b0, sda_bit);
                default:   byte_phase(1'b1, sda_bit);
            endcase
            if (phase == final_phase(active_cmd))
            begin
                done = 1'b1;
                active_cmd = CMD_IDLE;
                phase = '0;
            end
            else
                phase = phase + 5'd1;
        end
        view = '{scl_q, sda_q, busy, done, rx_q, slave_ack_q};
    endtask

    task automatic compare_field(input string name, input int expected_val, input int actual_val);
        if (expected_val != actual_val)
        begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t: %s expected %0h, got %0h", $time, name, expected_val, actual_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cmd = CMD_IDLE;
            phase = '0;
            shifter = '0;
            ack_sel = 1'b0;
            slave_ack_q = 1'b0;
            scl_q = 1'b0;
            sda_q = 1'b0;
            rx_q = '0;
            predicted_views.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // retire first: a result never belongs to the item taken at the same edge
            if (out_valid && out_ready)
            begin
                got = '{scl_low, sda_low, busy_res, done_res, rx_data, slave_acked};
                if (predicted_views.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got %0h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = predicted_views.pop_front();
                    compare_field("scl_low", want.scl, got.scl);
                    compare_field("sda_low", want.sda, got.sda);
                    compare_field("busy_res", want.busy, got.busy);
                    compare_field("done_res", want.done, got.done);
                    compare_field("rx_data", want.rx, got.rx);
                    compare_field("slave_acked", want.acked, got.acked);
                end
            end
            if (in_valid && in_ready)
            begin
                advance_tick(op, tx_data, master_ack, sda_in, want);
                predicted_views.push_back(want);
            end
            pending <= predicted_views.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam int GAP_MAX         = 5;
    localparam int TICK_TARGET     = 1150;
    localparam int DRAIN_AT        = 700;
    localparam int HOLD_AT         = 400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 10;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [2:0]  op         = OP_TICK;
    logic [7:0]  tx_data    = 8'h00;
    logic        master_ack = 1'b0;
    logic        sda_in     = 1'b1;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        scl_low;
    logic        sda_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_data;
    logic        slave_acked;
    int unsigned pending;
    int unsigned fail_count;

    int unsigned ticks_sent    = 0;
    int unsigned results_taken = 0;
    bit          steady        = 1'b0;

    i2c_master_bit_sequencer_unit i_dut (.*);

    i2c_bus_checker i_checker (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int bus_ticks(input logic [2:0] code);
        case (code)
            OP_START, OP_STOP:  return 3;
            OP_RSTART:          return 4;
            OP_WRITE, OP_READ:  return BYTE_TICKS;
            default:            return 1;
        endcase
    endfunction

    task automatic send_tick(input logic [2:0] code, input logic [7:0] tx,
                             input logic mack, input logic sda_bit);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        tx_data    <= tx;
        master_ack <= mack;
        sda_in     <= sda_bit;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // Command item, then plain ticks to the end of the sequence; noise_pct of them
    // carry a random op that the busy sequencer must ignore.
    task automatic run_command(input logic [2:0] code, input logic [7:0] tx, input logic mack,
                               input int sda_mode, input int noise_pct);
        int         ticks;
        logic [2:0] filler;
        logic       sda_bit;
        ticks = bus_ticks(code);
        for (int k = 0; k < ticks; k++)
        begin
            sda_bit = (sda_mode == SDA_RANDOM) ? 1'($urandom) : 1'(sda_mode);
            if (k == 0)
                send_tick(code, tx, mack, sda_bit);
            else
            begin
                filler = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : OP_TICK;
                send_tick(filler, 8'($urandom), 1'($urandom), sda_bit);
            end
        end
    endtask

    task automatic idle_ticks();
        logic [2:0] code;
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       code = OP_SPARE6;
                1:       code = OP_SPARE7;
                default: code = OP_TICK;
            endcase
            send_tick(code, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_byte();
        run_command($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom), 1'($urandom),
                    SDA_RANDOM, 10);
        idle_ticks();
    endtask

    task automatic run_transaction();
        run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
        idle_ticks();
        repeat ($urandom_range(1, 3)) run_byte();
        if ($urandom_range(0, 2) == 0)
        begin
            run_command(OP_RSTART, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
            idle_ticks();
            run_byte();
        end
        run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
        idle_ticks();
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin : stimulus
        bit drained;
        drained = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_tick(OP_SPARE7, 8'hFF, 1'b1, 1'b0);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 100);
        run_command(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
        run_command(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 50);
        run_command(OP_READ, 8'hFF, 1'b1, SDA_HIGH, 0);
        run_command(OP_RSTART, 8'h5A, 1'b1, SDA_RANDOM, 100);
        run_command(OP_READ, 8'h00, 1'b0, SDA_LOW, 50);
        run_command(OP_STOP, 8'hA5, 1'b0, SDA_RANDOM, 0);
        send_tick(OP_SPARE6, 8'h00, 1'b0, 1'b1);
        send_tick(OP_TICK, 8'hFF, 1'b1, 1'b0);
        drain_results();

        while (ticks_sent < TICK_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 15)
            begin
                // broken sequences: commands anywhere, fields anything
                repeat ($urandom_range(1, 6))
                    send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                              1'($urandom));
            end
            else
                run_transaction();
            if (!drained && ticks_sent > DRAIN_AT)
            begin
                drain_results();
                drained = 1'b1;
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_taken == HOLD_AT)
            begin
                // stall long enough for the block to back up and drop in_ready
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = ((results_taken / 100) % 3 == 0) ? 0 : $urandom_range(0, GAP_MAX);
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

endmodule

### files.f
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_sequencer_unit.sv
test/i2c_bus_checker.sv
test/testbench.sv
